// ----- rtl/double_ended_queue_assert.svh -----
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`else

`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/deq_pkg.sv -----
package deq_pkg;

	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_REVERSE    = 3'd4;

	localparam logic [1:0] FAULT_OK    = 2'd0;
	localparam logic [1:0] FAULT_EMPTY = 2'd1;
	localparam logic [1:0] FAULT_FULL  = 2'd2;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic grow;     // one entry more: occupancy takes the left neighbour's
		logic shrink;   // one entry less: occupancy takes the right neighbour's
		logic shift_r;  // insert at the physical start
		logic shift_l;  // remove at the physical start
		logic put_end;  // append at the physical end
	} deq_cmd_t;

endpackage

// ----- rtl/deq_cell.sv -----
module deq_cell #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  deq_pkg::deq_cmd_t     cmd,
	input  logic [DATA_WIDTH-1:0] push_value,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  left_occ,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  right_occ,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  occ,
	output logic [DATA_WIDTH-1:0] tail_data
);
	import deq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  occ_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_r) begin
			data_q <= left_data;
		end else if (cmd.shift_l) begin
			data_q <= right_data;
		end else if (cmd.put_end && left_occ && !occ_q) begin
			// first free cell takes the appended item
			data_q <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.grow) begin
			occ_q <= left_occ;
		end else if (cmd.shrink) begin
			occ_q <= right_occ;
		end
	end

	assign data      = data_q;
	assign occ       = occ_q;
	assign tail_data = (occ_q && !right_occ) ? data_q : '0;

endmodule

// ----- rtl/double_ended_queue.sv -----
// channel | direction | handshake         | fields
// in      | into      | in_valid/in_stall | req_type, item_value
// out     | out of    | out_valid/out_stall | popped_value, fault, entry_count, is_empty
//
// One request per cycle while the result register drains; a request is taken
// in the same cycle as the result before it leaves. Its result is registered and shows in the next cycle.
// Entries sit packed from cell 0 of a row of DEPTH cells; a start-end push or pop
// shifts the whole row one place, an end push or pop touches only the boundary cell.
// Reset clears the occupancy flags, the count and the orientation; slot data is not reset.
// in_stall is high while a result is held and out_stall is high.
module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   req_type,
	input  logic [DATA_WIDTH-1:0]        item_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [DATA_WIDTH-1:0]        popped_value,
	output logic [1:0]                   fault,
	output logic [$clog2(DEPTH+1)-1:0]   entry_count,
	output logic                         is_empty
);
	import deq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
	logic [DEPTH-1:0]      occ;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  flipped_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] popped_q;
	logic [1:0]            fault_q;
	logic [CNT_W-1:0]      count_out_q;
	logic                  empty_out_q;

	logic                  acc;
	logic                  is_push;
	logic                  is_pop;
	logic                  at_start;
	logic                  full;
	logic                  empty;
	logic                  do_push;
	logic                  do_pop;
	deq_cmd_t              cmd;
	logic [DATA_WIDTH-1:0] tail_sel;
	logic [DATA_WIDTH-1:0] popped_nxt;
	logic [1:0]            fault_nxt;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	assign is_push  = (req_type == REQ_PUSH_BACK) || (req_type == REQ_PUSH_FRONT);
	assign is_pop   = (req_type == REQ_POP_BACK) || (req_type == REQ_POP_FRONT);
	// logical front maps to the physical start unless reversed
	assign at_start = ((req_type == REQ_PUSH_FRONT) || (req_type == REQ_POP_FRONT)) ^ flipped_q;
	assign full     = occ[DEPTH-1];
	assign empty    = !occ[0];
	assign do_push  = acc && is_push && !full;
	assign do_pop   = acc && is_pop && !empty;

	always_comb begin
		cmd.grow    = do_push;
		cmd.shrink  = do_pop;
		cmd.shift_r = do_push && at_start;
		cmd.put_end = do_push && !at_start;
		cmd.shift_l = do_pop && at_start;
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_WIDTH-1:0] l_data;
			logic                  l_occ;
			logic [DATA_WIDTH-1:0] r_data;
			logic                  r_occ;

			if (gi == 0) begin : g_first
				assign l_data = item_value;
				assign l_occ  = 1'b1;
			end else begin : g_mid_l
				assign l_data = cell_data[gi-1];
				assign l_occ  = occ[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign r_data = cell_data[gi];
				assign r_occ  = 1'b0;
			end else begin : g_mid_r
				assign r_data = cell_data[gi+1];
				assign r_occ  = occ[gi+1];
			end

			deq_cell #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.push_value (item_value),
				.left_data  (l_data),
				.left_occ   (l_occ),
				.right_data (r_data),
				.right_occ  (r_occ),
				.data       (cell_data[gi]),
				.occ        (occ[gi]),
				.tail_data  (cell_tail[gi])
			);
		end
	endgenerate

	// only the last occupied cell drives a non-zero tail
	always_comb begin
		tail_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_sel = tail_sel | cell_tail[i];
		end
	end

	always_comb begin
		count_nxt  = count_q;
		popped_nxt = '0;
		fault_nxt  = FAULT_OK;
		if (do_push) begin
			count_nxt = count_q + 1'b1;
		end else if (do_pop) begin
			count_nxt  = count_q - 1'b1;
			popped_nxt = at_start ? cell_data[0] : tail_sel;
		end
		if (is_push && full) begin
			fault_nxt = FAULT_FULL;
		end else if (is_pop && empty) begin
			fault_nxt = FAULT_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flipped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
				if (req_type == REQ_REVERSE) begin
					flipped_q <= !flipped_q;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			popped_q    <= popped_nxt;
			fault_q     <= fault_nxt;
			count_out_q <= count_nxt;
			empty_out_q <= (count_nxt == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign fault        = fault_q;
	assign entry_count  = count_out_q;
	assign is_empty     = empty_out_q;

	`include "double_ended_queue_assert.svh"

	`DEQ_ASSERT_NOW(a_occ_matches_count, clk, arst_n, 1'b1, occ[0] == (count_q != '0))
	`DEQ_ASSERT_NOW(a_occ_thermometer, clk, arst_n, 1'b1, (occ & (occ + 1'b1)) == '0)
	`DEQ_ASSERT_NEXT(a_full_push_refused, clk, arst_n, acc && is_push && full, (fault == FAULT_FULL) && $stable(count_q))
	`DEQ_ASSERT_NEXT(a_empty_pop_zero, clk, arst_n, acc && is_pop && empty, (fault == FAULT_EMPTY) && (popped_value == '0))

endmodule
